// ===== sv/sfpa_pkg.sv =====
// Shared types, codes and the clamping helper for the saturating fixed-point ALU.
// Used by sfpa_div, saturating_fixed_point_alu_core, sfpa_checker and the test. No dependencies.
package sfpa_pkg;

  localparam int ValW  = 33;  // raw operand / result width
  localparam int MagW  = 33;  // magnitude of a clamped operand
  localparam int DivW  = 65;  // magnitude << fraction_bits
  localparam int QuotW = 34;  // quotient bits developed by the divider
  localparam int ProdW = 66;  // magnitude product
  localparam int ClmpW = 67;  // widest magnitude given to the clamp

  localparam logic RST_SIGNED = 1'b1;
  localparam logic [5:0] RST_INT_BITS = 6'd5;
  localparam logic [5:0] RST_FRAC_BITS = 6'd10;

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_SIGNED_MODE   = 2'd0,
    REG_INTEGER_BITS  = 2'd1,
    REG_FRACTION_BITS = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]      f;
    val_t            hi;
    val_t            lo;
    logic [MagW-1:0] lomag;
  } fmt_t;

  // per-transaction info that rides alongside the divider
  typedef struct packed {
    cmd_t    cmd;
    logic    sat;
    logic    neg;
    logic    aneg;
    logic    bz;
    val_t    res;
    status_t st;
  } side_t;

  typedef struct packed {
    val_t v;
    logic sat;
  } clamp_t;

  // sign plus magnitude clamped to the format range
  function automatic clamp_t clamp_mag(logic neg, logic [ClmpW-1:0] mag, fmt_t fmt);
    clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > ClmpW'(fmt.lomag)) begin
        r.v   = fmt.lo;
        r.sat = 1'b1;
      end else begin
        r.v = ValW'(ClmpW'(0) - mag);
      end
    end else begin
      if (mag > ClmpW'($unsigned(fmt.hi))) begin
        r.v   = fmt.hi;
        r.sat = 1'b1;
      end else begin
        r.v = ValW'(mag);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/sfpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on sfpa_pkg.
module sfpa_div import sfpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DivW-1:0]  in_dividend,
  input  logic [MagW-1:0]  in_divisor,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [QuotW-1:0] out_quot,
  output logic             out_ovf,
  output side_t            out_side
);

  logic             v_r    [0:QuotW];
  logic [MagW-1:0]  rem_r  [0:QuotW];
  logic [QuotW-1:0] low_r  [0:QuotW];
  logic [QuotW-1:0] quo_r  [0:QuotW];
  logic [MagW-1:0]  dv_r   [0:QuotW];
  logic             ovf_r  [0:QuotW];
  side_t            side_r [0:QuotW];

  // entry: quotient would need more than QuotW bits when the top part reaches the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      rem_r[0]  <= MagW'(in_dividend[DivW-1:QuotW]);
      low_r[0]  <= in_dividend[QuotW-1:0];
      quo_r[0]  <= '0;
      dv_r[0]   <= in_divisor;
      ovf_r[0]  <= MagW'(in_dividend[DivW-1:QuotW]) >= in_divisor;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [MagW:0] trial;
    logic          ge;
    logic [MagW:0] diff;

    assign trial = {rem_r[k], low_r[k][QuotW-1-k]};
    assign ge    = trial >= {1'b0, dv_r[k]};
    assign diff  = trial - {1'b0, dv_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
      if (en) begin
        rem_r[k+1]  <= ge ? diff[MagW-1:0] : trial[MagW-1:0];
        low_r[k+1]  <= low_r[k];
        quo_r[k+1]  <= {quo_r[k][QuotW-2:0], ge};
        dv_r[k+1]   <= dv_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[QuotW];
  assign out_quot  = quo_r[QuotW];
  assign out_ovf   = ovf_r[QuotW];
  assign out_side  = side_r[QuotW];

endmodule

// ===== sv/saturating_fixed_point_alu_core.sv =====
// Saturating fixed-point ALU: add, subtract, multiply, divide on raw operands.
// Depends on sfpa_pkg and sfpa_div.
//
// Input channel in_valid/in_ready carries in_cmd, in_operand_a, in_operand_b;
// result channel out_valid/out_ready carries out_result_value and out_status.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes signed_mode,
// integer_bits and fraction_bits; write it only while no transaction is in flight.
// Every command passes 42 register stages: six front stages (capture, operand clamp,
// add/magnitude, add clamp with 32x32 multiply, partial product sum, fraction shift;
// the product clamp is combinational into the divider), the divider's entry register
// plus 34 stages at one quotient bit each, and the output register. One transaction
// is accepted every cycle while the output is taken.
// The whole pipeline advances together; when out_valid is high and out_ready low
// it holds, and in_ready drops until the result is taken. Nothing is lost.
// Reset (synchronous, rst_n low) empties the pipeline and restores the default
// format: signed, 5 integer bits, 10 fraction bits.
module saturating_fixed_point_alu_core import sfpa_pkg::*; #(
  parameter int MAX_WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic signed [ValW-1:0] in_operand_a,
  input  logic signed [ValW-1:0] in_operand_b,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [ValW-1:0] out_result_value,
  output logic [1:0]             out_status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [5:0]             cfg_data
);

  localparam logic [5:0] MaxW = 6'(MAX_WORD_BITS);

  logic en;

  // ---------------- configuration ----------------
  logic       sgn_r;
  logic [5:0] ibits_r, fbits_r;
  fmt_t       fmt_r, fmt_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgn_r   <= RST_SIGNED;
      ibits_r <= RST_INT_BITS;
      fbits_r <= RST_FRAC_BITS;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SIGNED_MODE:   sgn_r   <= cfg_data[0];
        REG_INTEGER_BITS:  ibits_r <= cfg_data;
        REG_FRACTION_BITS: fbits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [5:0]  room, f, i, m;
    logic [ValW:0] pw;
    room = MaxW - {5'd0, sgn_r};
    f    = (fbits_r > room) ? room : fbits_r;
    i    = (ibits_r > (room - f)) ? (room - f) : ibits_r;
    m    = i + f;
    pw   = (ValW+1)'(1) << m;
    fmt_nxt.f     = f;
    fmt_nxt.hi    = ValW'(pw - (ValW+1)'(1));
    fmt_nxt.lomag = sgn_r ? MagW'(pw) : '0;
    fmt_nxt.lo    = ValW'(MagW'(0) - fmt_nxt.lomag);
  end

  always_ff @(posedge clk) begin
    fmt_r <= fmt_nxt;
  end

  // ---------------- pipeline ----------------
  logic        out_valid_r;
  val_t        out_res_r;
  status_t     out_st_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // s1: capture
  logic v1_r;
  cmd_t cmd1_r;
  val_t a1_r, b1_r;

  // s2: operand clamp
  logic v2_r, sat2_r;
  cmd_t cmd2_r;
  val_t a2_r, b2_r;
  logic a_hi, a_lo, b_hi, b_lo;

  assign a_hi = a1_r > fmt_r.hi;
  assign a_lo = a1_r < fmt_r.lo;
  assign b_hi = b1_r > fmt_r.hi;
  assign b_lo = b1_r < fmt_r.lo;

  // s3: sum/difference and magnitudes
  logic              v3_r;
  side_t             side3_r;
  logic signed [ValW:0] t3_r;
  logic [MagW-1:0]   ma3_r, mb3_r;
  logic signed [ValW:0] sa, sb;

  assign sa = {a2_r[ValW-1], a2_r};
  assign sb = {b2_r[ValW-1], b2_r};

  // s4: add clamp, low product, dividend
  logic              v4_r;
  side_t             side4_r, side4_nxt;
  logic [63:0]       pll4_r;
  logic [MagW-1:0]   ma4_r, mb4_r;
  logic [DivW-1:0]   dvd4_r;
  logic signed [ValW:0] hi34, lo34;

  assign hi34 = {fmt_r.hi[ValW-1], fmt_r.hi};
  assign lo34 = {fmt_r.lo[ValW-1], fmt_r.lo};

  always_comb begin
    side4_nxt = side3_r;
    if (t3_r > hi34) begin
      side4_nxt.res = fmt_r.hi;
      side4_nxt.st  = ST_SAT;
    end else if (t3_r < lo34) begin
      side4_nxt.res = fmt_r.lo;
      side4_nxt.st  = ST_SAT;
    end else begin
      side4_nxt.res = ValW'(t3_r);
      side4_nxt.st  = side3_r.sat ? ST_SAT : ST_OK;
    end
  end

  // s5: full product
  logic            v5_r;
  side_t           side5_r;
  logic [ProdW-1:0] p5_r;
  logic [MagW-1:0] mb5_r;
  logic [DivW-1:0] dvd5_r;

  // s6: fraction shift
  logic            v6_r;
  side_t           side6_r;
  logic [ProdW-1:0] ps6_r;
  logic [MagW-1:0] mb6_r;
  logic [DivW-1:0] dvd6_r;

  // s7 (combinational into divider): product clamp
  side_t  side7;
  clamp_t mc;

  always_comb begin
    mc    = clamp_mag(side6_r.neg && (ps6_r != '0), ClmpW'(ps6_r), fmt_r);
    side7 = side6_r;
    if (side6_r.cmd == CMD_MUL) begin
      side7.res = mc.v;
      side7.st  = (side6_r.sat || mc.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    if (en) begin
      cmd1_r <= cmd_t'(in_cmd);
      a1_r   <= in_operand_a;
      b1_r   <= in_operand_b;

      cmd2_r <= cmd1_r;
      a2_r   <= a_hi ? fmt_r.hi : (a_lo ? fmt_r.lo : a1_r);
      b2_r   <= b_hi ? fmt_r.hi : (b_lo ? fmt_r.lo : b1_r);
      sat2_r <= a_hi || a_lo || b_hi || b_lo;

      side3_r.cmd  <= cmd2_r;
      side3_r.sat  <= sat2_r;
      side3_r.neg  <= a2_r[ValW-1] ^ b2_r[ValW-1];
      side3_r.aneg <= a2_r[ValW-1];
      side3_r.bz   <= b2_r == '0;
      side3_r.res  <= '0;
      side3_r.st   <= ST_OK;
      t3_r  <= (cmd2_r == CMD_SUB) ? (sa - sb) : (sa + sb);
      ma3_r <= a2_r[ValW-1] ? MagW'(MagW'(0) - MagW'(a2_r)) : MagW'(a2_r);
      mb3_r <= b2_r[ValW-1] ? MagW'(MagW'(0) - MagW'(b2_r)) : MagW'(b2_r);

      side4_r <= side4_nxt;
      pll4_r  <= ma3_r[31:0] * mb3_r[31:0];
      ma4_r   <= ma3_r;
      mb4_r   <= mb3_r;
      dvd4_r  <= DivW'(ma3_r) << fmt_r.f;

      side5_r <= side4_r;
      p5_r    <= ProdW'(pll4_r)
               + (mb4_r[32] ? (ProdW'(ma4_r[31:0]) << 32) : '0)
               + (ma4_r[32] ? (ProdW'(mb4_r[31:0]) << 32) : '0)
               + ((ma4_r[32] && mb4_r[32]) ? (ProdW'(1) << 64) : '0);
      mb5_r   <= mb4_r;
      dvd5_r  <= dvd4_r;

      side6_r <= side5_r;
      ps6_r   <= p5_r >> fmt_r.f;
      mb6_r   <= mb5_r;
      dvd6_r  <= dvd5_r;
    end
  end

  // divider
  logic             dv_valid, dv_ovf;
  logic [QuotW-1:0] dv_quot;
  side_t            dv_side;

  sfpa_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v6_r),
    .in_dividend (dvd6_r),
    .in_divisor  (mb6_r),
    .in_side     (side7),
    .out_valid   (dv_valid),
    .out_quot    (dv_quot),
    .out_ovf     (dv_ovf),
    .out_side    (dv_side)
  );

  // final select
  val_t    res_nxt;
  status_t st_nxt;
  clamp_t  qc;

  always_comb begin
    logic [ClmpW-1:0] qm;
    qm = dv_ovf ? '1 : ClmpW'(dv_quot);
    qc = clamp_mag(dv_side.neg && (dv_ovf || dv_quot != '0), qm, fmt_r);
    res_nxt = dv_side.res;
    st_nxt  = dv_side.st;
    if (dv_side.cmd == CMD_DIV) begin
      if (dv_side.bz) begin
        res_nxt = dv_side.aneg ? fmt_r.lo : fmt_r.hi;
        st_nxt  = ST_DIV0;
      end else begin
        res_nxt = qc.v;
        st_nxt  = (dv_side.sat || qc.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
    if (en) begin
      out_res_r <= res_nxt;
      out_st_r  <= st_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_st_r;

  // ---------------- checks ----------------
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_OK) |-> (out_res_r <= fmt_r.hi) && (out_res_r >= fmt_r.lo))
    else $error("exact result outside format range");

  a_div0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_DIV0) |-> (out_res_r == fmt_r.hi) || (out_res_r == fmt_r.lo))
    else $error("divide-by-zero result not at a format bound");

  a_no_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_st_r != ST_RSVD)
    else $error("reserved status code on output");

endmodule

// ===== tb/sfpa_checker.sv =====
// Checker for the saturating fixed-point ALU: watches the config, input and result channels,
// predicts each result from the current format and compares field by field.
// Depends on sfpa_pkg.
module sfpa_checker import sfpa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic signed [ValW-1:0] in_operand_a,
  input  logic signed [ValW-1:0] in_operand_b,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic signed [ValW-1:0] out_result_value,
  input  logic [1:0]             out_status,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [5:0]             cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     results_seen
);

  typedef struct {
    val_t    value;
    status_t st;
  } alu_result_t;

  alu_result_t expected_results[$];
  logic       fmt_signed;
  logic [5:0] fmt_int, fmt_frac;

  assign pending = expected_results.size();

  // Arithmetic in 128-bit signed to keep products and shifted dividends exact.
  function automatic alu_result_t predict_alu(logic [1:0] cmd, val_t a_raw, val_t b_raw);
    alu_result_t r;
    int unsigned room, f, i, m;
    longint hi, lo;
    logic signed [127:0] a, b, t, mag, lim;
    logic sat, neg, div0;
    room = 32 - fmt_signed;
    f = fmt_frac;
    i = fmt_int;
    if (f > room) f = room;
    if (i > room - f) i = room - f;
    m = i + f;
    hi = (longint'(1) << m) - 1;
    lo = fmt_signed ? -(longint'(1) << m) : 0;
    sat = 0;
    div0 = 0;
    a = a_raw;
    b = b_raw;
    if (a > hi) begin a = hi; sat = 1; end
    if (a < lo) begin a = lo; sat = 1; end
    if (b > hi) begin b = hi; sat = 1; end
    if (b < lo) begin b = lo; sat = 1; end
    neg = (a < 0) != (b < 0);
    case (cmd_t'(cmd))
      CMD_ADD, CMD_SUB: begin
        t = (cmd_t'(cmd) == CMD_ADD) ? a + b : a - b;
        neg = t < 0;
        mag = neg ? -t : t;
      end
      CMD_MUL: begin
        mag = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> f;
        neg = neg && mag != 0;
      end
      default: begin
        if (b == 0) begin
          div0 = 1;
          mag = 0;
        end else begin
          mag = ((a < 0 ? -a : a) <<< f) / (b < 0 ? -b : b);
          neg = neg && mag != 0;
        end
      end
    endcase
    if (div0) begin
      r.value = (a < 0) ? val_t'(lo) : val_t'(hi);
    end else if (neg) begin
      lim = -lo;
      if (mag > lim) begin r.value = val_t'(lo); sat = 1; end
      else r.value = val_t'(-mag);
    end else begin
      if (mag > hi) begin r.value = val_t'(hi); sat = 1; end
      else r.value = val_t'(mag);
    end
    r.st = div0 ? ST_DIV0 : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      fmt_signed <= RST_SIGNED;
      fmt_int <= RST_INT_BITS;
      fmt_frac <= RST_FRAC_BITS;
      expected_results.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SIGNED_MODE:   fmt_signed <= cfg_data[0];
          REG_INTEGER_BITS:  fmt_int <= cfg_data;
          REG_FRACTION_BITS: fmt_frac <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_alu(in_cmd, in_operand_a, in_operand_b));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result value=%0d status=%0d",
                                    out_result_value, out_status);
        end else begin
          want = expected_results.pop_front();
          if (out_result_value !== want.value || out_status !== want.st) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                       want.value, want.st, out_result_value, out_status);
          end
        end
      end
    end
  end

endmodule

// ===== tb/saturating_fixed_point_alu_core_test.sv =====
// Stimulus and verdict for saturating_fixed_point_alu_core: directed and random
// transactions over several formats and idle mixes. Depends on sfpa_pkg, sfpa_checker and the core.
module saturating_fixed_point_alu_core_test;
  import sfpa_pkg::*;

  localparam int Latency = 43;
  localparam int CycleLimit = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_cmd = CMD_ADD;
  val_t in_operand_a = 0, in_operand_b = 0;
  logic out_valid, out_ready = 0;
  val_t out_result_value;
  logic [1:0] out_status;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = REG_SIGNED_MODE;
  logic [5:0] cfg_data = 0;
  int errors, pending, results_seen;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int cycles = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  saturating_fixed_point_alu_core dut (.*);

  sfpa_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  // Format range of the current setting, for picking operands mostly in range.
  logic cur_s;
  logic [5:0] cur_i, cur_f;

  function automatic val_t pick_operand();
    int unsigned room, f, i, m;
    longint hi, lo;
    room = 32 - cur_s;
    f = cur_f;
    i = cur_i;
    if (f > room) f = room;
    if (i > room - f) i = room - f;
    m = i + f;
    hi = (longint'(1) << m) - 1;
    lo = cur_s ? -(longint'(1) << m) : 0;
    case ($urandom_range(9))
      0: return val_t'(hi);
      1: return val_t'(lo);
      2: return 0;
      3: return val_t'({$urandom, $urandom});
      4: return val_t'($urandom_range(3));
      default: return val_t'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
    endcase
  endfunction

  // in_valid stays high between back-to-back transactions; it only drops for idle cycles
  task automatic send_op(logic [1:0] cmd, val_t a, val_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [5:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SIGNED_MODE:   cur_s = data[0];
      REG_INTEGER_BITS:  cur_i = data;
      REG_FRACTION_BITS: cur_f = data;
      default: ;
    endcase
  endtask

  task automatic set_format(logic s, logic [5:0] ib, logic [5:0] fb);
    drain();
    write_reg(REG_SIGNED_MODE, {5'd0, s});
    write_reg(REG_INTEGER_BITS, ib);
    write_reg(REG_FRACTION_BITS, fb);
    cfg_valid <= 0;
  endtask

  task automatic random_ops(int n);
    repeat (n) send_op(2'($urandom_range(3)), pick_operand(), pick_operand());
  endtask

  initial begin
    cur_s = RST_SIGNED;
    cur_i = RST_INT_BITS;
    cur_f = RST_FRAC_BITS;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: default, unsigned and extreme formats, every op, extremes, div by zero, out-of-range operands
    send_op(CMD_ADD, 33'sd32767, 33'sd1);
    send_op(CMD_SUB, -33'sd32768, 33'sd1);
    send_op(CMD_MUL, 33'sd32767, 33'sd32767);
    send_op(CMD_MUL, -33'sd32768, 33'sd1024);
    send_op(CMD_MUL, -33'sd1, 33'sd1);
    send_op(CMD_DIV, 33'sd100, 33'sd0);
    send_op(CMD_DIV, -33'sd100, 33'sd0);
    send_op(CMD_DIV, 33'sd1024, -33'sd3);
    send_op(CMD_DIV, -33'sd32768, 33'sd1);
    send_op(CMD_ADD, 33'sh0FFFFFFFF, -33'sh100000000);
    send_op(CMD_SUB, 33'sd0, 33'sd0);
    set_format(1'b0, 6'd22, 6'd10);
    send_op(CMD_SUB, 33'sd1, 33'sd2);
    send_op(CMD_ADD, 33'sh0FFFFFFFF, 33'sh0FFFFFFFF);
    send_op(CMD_MUL, 33'sh0FFFFFFFF, 33'sh0FFFFFFFF);
    send_op(CMD_DIV, 33'sh0FFFFFFFF, 33'sd1);
    send_op(CMD_DIV, 33'sd0, 33'sd0);
    send_op(CMD_ADD, -33'sd5, 33'sd3);
    set_format(1'b1, 6'd63, 6'd63);
    send_op(CMD_MUL, -33'sh80000000, -33'sh80000000);
    send_op(CMD_DIV, 33'sd1, 33'sd1);
    set_format(1'b1, 6'd0, 6'd0);
    send_op(CMD_ADD, 33'sd0, -33'sd1);
    send_op(CMD_MUL, -33'sd1, -33'sd1);
    send_op(CMD_DIV, -33'sd1, -33'sd1);

    // random phases over formats and idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      set_format(1'($urandom), 6'($urandom_range(40)), 6'($urandom_range(40)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      random_ops(ph == 0 ? 30 : 60);
    end

    // long receiver hold-off while inputs keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (150) @(posedge clk);
        hold_off = 0;
      end
      random_ops(80);
    join

    drain();
    $display("Ran %0d transactions, %0d results checked, over signed/unsigned formats",
             items_sent, results_seen);
    $display("including extreme widths, divide by zero and backpressure.");
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
